// ===== rtl/caht_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers of the clustered aging hash table.
// Used by caht_engine and the top level; has no dependencies of its own.
package caht_pkg;

  localparam int INDEX_BITS_DEF   = 10;
  localparam int CLUSTER_WAYS_DEF = 4;
  localparam int DATE_COUNT_DEF   = 16;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_INFINITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_ABSENT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_ABSENT    = 2'd2;

  localparam logic [1:0] MODE_STORE    = 2'd0;
  localparam logic [1:0] MODE_RETRIEVE = 2'd1;
  localparam logic [1:0] MODE_ADVANCE  = 2'd2;
  localparam logic [1:0] MODE_CLEAR    = 2'd3;

  localparam logic [14:0]        VALUE_INFINITY_RST = 15'd30001;
  localparam logic signed [15:0] VALUE_ABSENT_RST   = -16'sd32767;
  localparam logic [15:0]        MOVE_ABSENT_RST    = 16'd0;

  localparam logic signed [7:0] DEPTH_NONE = -8'sd128;
  // Age counts 256 depth units: the score is age * 2^AGE_SHIFT minus depth.
  localparam int AGE_SHIFT = 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_UPDATE,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0]        lock;
    logic [15:0]        mv_code;
    logic signed [7:0]  mv_depth;
    logic signed [7:0]  lo_depth;
    logic signed [7:0]  up_depth;
    logic signed [15:0] lo_val;
    logic signed [15:0] up_val;
    logic signed [15:0] eval;
  } entry_t;

  typedef struct packed {
    logic               found;
    logic [15:0]        hit_move;
    logic signed [7:0]  hit_lower_depth;
    logic signed [7:0]  hit_upper_depth;
    logic signed [15:0] hit_lower_bound;
    logic signed [15:0] hit_upper_bound;
    logic signed [15:0] hit_eval;
  } result_t;

  function automatic logic signed [7:0] max3(input logic signed [7:0] a,
                                             input logic signed [7:0] b,
                                             input logic signed [7:0] c);
    logic signed [7:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

endpackage

// ===== rtl/caht_mem.sv =====
`timescale 1ns / 1ps
// Single-port synchronous entry memory with a registered read.
// Stand-alone; holds one cluster slot per word.
module caht_mem #(
  parameter int DEPTH = 1027,
  parameter int AW    = 11,
  parameter int DW    = 148
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          we,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/caht_engine.sv =====
`timescale 1ns / 1ps
// Probe, replacement and clearing sequencer of the hash table.
// Depends on caht_pkg and drives the caht_mem entry memory.
module caht_engine #(
  parameter int INDEX_BITS   = caht_pkg::INDEX_BITS_DEF,
  parameter int CLUSTER_WAYS = caht_pkg::CLUSTER_WAYS_DEF,
  parameter int DATE_COUNT   = caht_pkg::DATE_COUNT_DEF,
  parameter int DB           = $clog2(DATE_COUNT)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           mode,
  input  logic [63:0]          key,
  input  logic [15:0]          move_code,
  input  logic signed [7:0]    search_depth,
  input  logic signed [15:0]   lower_bound,
  input  logic signed [15:0]   upper_bound,
  input  logic signed [15:0]   static_eval,
  input  logic                 refresh,
  input  logic [14:0]          value_infinity,
  input  logic signed [15:0]   value_absent,
  input  logic [15:0]          move_absent,
  input  logic                 res_ready,
  output logic                 res_valid,
  output caht_pkg::result_t    res,
  output logic [DB-1:0]        cur_date
);
  import caht_pkg::*;

  localparam int DEPTH = (1 << INDEX_BITS) + CLUSTER_WAYS - 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = $bits(entry_t);
  localparam int DW    = EW + DB;
  localparam int WB    = (CLUSTER_WAYS > 1) ? $clog2(CLUSTER_WAYS) : 1;
  localparam int IW    = $clog2(CLUSTER_WAYS + 1);
  localparam int SW    = DB + AGE_SHIFT + 2;

  state_t state, state_next;

  logic [1:0]         it_mode;
  logic [INDEX_BITS-1:0] it_base;
  logic [31:0]        it_lock;
  logic [15:0]        it_mv;
  logic signed [7:0]  it_depth;
  logic signed [15:0] it_lo, it_up, it_ev;
  logic               it_refresh;

  logic [IW-1:0]      iss;
  logic [WB-1:0]      chk;
  logic               rv;
  logic [AW-1:0]      best_addr, tgt_addr;
  logic signed [SW-1:0] lead_score;
  logic               hit;
  entry_t             hit_entry;

  logic [AW-1:0]      clr_cnt;
  logic               clr_emit;
  logic [14:0]        snap_inf;
  logic signed [15:0] snap_abs;
  logic [15:0]        snap_ma;

  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [DW-1:0] mem_wdata, mem_rdata;

  caht_mem #(.DEPTH(DEPTH), .AW(AW), .DW(DW)) u_mem (
    .clk  (clk),
    .addr (mem_addr),
    .we   (mem_we),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // Probe datapath: the entry that came back from the memory this cycle.
  entry_t             rd_entry;
  logic [DB-1:0]      rd_date;
  logic               lock_hit, last_way, take;
  logic [DB:0]        age_wide;
  logic signed [7:0]  maxd;
  logic signed [SW-1:0] score;
  logic [AW-1:0]      base_ext, chk_addr;
  logic [DB-1:0]      date_inc;

  assign rd_entry = entry_t'(mem_rdata[EW-1:0]);
  assign rd_date  = mem_rdata[DW-1 -: DB];
  assign lock_hit = rd_entry.lock == it_lock;
  assign last_way = chk == WB'(CLUSTER_WAYS - 1);
  assign base_ext = AW'(it_base);
  assign chk_addr = base_ext + AW'(chk);
  assign age_wide = (cur_date >= rd_date) ? {1'b0, cur_date} - {1'b0, rd_date}
                  : {1'b0, cur_date} + (DB+1)'(DATE_COUNT) - {1'b0, rd_date};
  assign maxd     = max3(rd_entry.mv_depth, rd_entry.lo_depth, rd_entry.up_depth);
  assign score    = $signed({2'b00, age_wide[DB-1:0], AGE_SHIFT'(0)})
                  - SW'(maxd);
  // The first way always wins over the empty start, later ones only when strictly better.
  assign take     = (chk == '0) || (score > lead_score);
  assign date_inc = (cur_date == DB'(DATE_COUNT - 1)) ? '0 : cur_date + DB'(1);

  // Store datapath.
  logic signed [15:0] neg_inf, pos_inf;
  logic has_mv, has_lo, has_up;
  entry_t upd_entry, new_entry, clr_entry;

  assign pos_inf = $signed({1'b0, value_infinity});
  assign neg_inf = -pos_inf;
  assign has_mv  = it_mv != move_absent;
  assign has_lo  = it_lo > neg_inf;
  assign has_up  = it_up < pos_inf;

  always_comb begin
    upd_entry = hit_entry;
    if (it_ev != value_absent) begin
      upd_entry.eval = it_ev;
    end
    if (has_mv && it_depth >= hit_entry.mv_depth) begin
      upd_entry.mv_depth = it_depth;
      upd_entry.mv_code  = it_mv;
    end
    if (has_lo && it_depth >= hit_entry.lo_depth) begin
      upd_entry.lo_depth = it_depth;
      upd_entry.lo_val   = it_lo;
    end
    if (has_up && it_depth >= hit_entry.up_depth) begin
      upd_entry.up_depth = it_depth;
      upd_entry.up_val   = it_up;
    end

    new_entry.lock     = it_lock;
    new_entry.mv_code  = it_mv;
    new_entry.mv_depth = has_mv ? it_depth : DEPTH_NONE;
    new_entry.lo_depth = has_lo ? it_depth : DEPTH_NONE;
    new_entry.up_depth = has_up ? it_depth : DEPTH_NONE;
    new_entry.lo_val   = it_lo;
    new_entry.up_val   = it_up;
    new_entry.eval     = it_ev;

    clr_entry.lock     = '0;
    clr_entry.mv_code  = snap_ma;
    clr_entry.mv_depth = DEPTH_NONE;
    clr_entry.lo_depth = DEPTH_NONE;
    clr_entry.up_depth = DEPTH_NONE;
    clr_entry.lo_val   = -$signed({1'b0, snap_inf});
    clr_entry.up_val   = $signed({1'b0, snap_inf});
    clr_entry.eval     = snap_abs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = state != S_IDLE;
    res_valid  = 1'b0;
    res        = '0;
    mem_we     = 1'b0;
    mem_addr   = base_ext + AW'(iss);
    mem_wdata  = {cur_date, hit_entry};
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (mode)
            MODE_STORE, MODE_RETRIEVE: state_next = S_PROBE;
            MODE_ADVANCE:              state_next = S_DONE;
            default:                   state_next = S_CLEAR;
          endcase
        end
      end
      S_PROBE: begin
        if (rv && (lock_hit || last_way)) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        mem_addr = tgt_addr;
        if (it_mode == MODE_STORE) begin
          mem_wdata = {cur_date, hit ? upd_entry : new_entry};
        end
        if (res_ready) begin
          res_valid = 1'b1;
          mem_we    = (it_mode == MODE_STORE) || (hit && it_refresh);
          if (it_mode == MODE_RETRIEVE && hit) begin
            res.found           = 1'b1;
            res.hit_move        = hit_entry.mv_code;
            res.hit_lower_depth = hit_entry.lo_depth;
            res.hit_upper_depth = hit_entry.up_depth;
            res.hit_lower_bound = hit_entry.lo_val;
            res.hit_upper_bound = hit_entry.up_val;
            res.hit_eval        = hit_entry.eval;
          end
          state_next = S_IDLE;
        end
      end
      S_CLEAR: begin
        mem_addr  = clr_cnt;
        mem_we    = 1'b1;
        mem_wdata = {DB'(0), clr_entry};
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = clr_emit ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_date <= '0;
      clr_cnt  <= '0;
      clr_emit <= 1'b0;
      rv       <= 1'b0;
      snap_inf <= VALUE_INFINITY_RST;
      snap_abs <= VALUE_ABSENT_RST;
      snap_ma  <= MOVE_ABSENT_RST;
    end else begin
      if (state == S_IDLE && in_valid) begin
        it_mode    <= mode;
        it_base    <= key[INDEX_BITS-1:0];
        it_lock    <= key[63:32];
        it_mv      <= move_code;
        it_depth   <= search_depth;
        it_lo      <= lower_bound;
        it_up      <= upper_bound;
        it_ev      <= static_eval;
        it_refresh <= refresh;
        iss        <= '0;
        chk        <= '0;
        rv         <= 1'b0;
        if (mode == MODE_ADVANCE) begin
          cur_date <= date_inc;
        end
        if (mode == MODE_CLEAR) begin
          cur_date <= '0;
          clr_cnt  <= '0;
          clr_emit <= 1'b1;
          snap_inf <= value_infinity;
          snap_abs <= value_absent;
          snap_ma  <= move_absent;
        end
      end
      if (state == S_PROBE) begin
        // Reads are issued one way per cycle and each is checked in the cycle after its issue.
        if (iss < IW'(CLUSTER_WAYS)) begin
          iss <= iss + IW'(1);
        end
        rv <= iss < IW'(CLUSTER_WAYS);
        if (rv) begin
          chk <= chk + WB'(1);
          if (lock_hit) begin
            hit       <= 1'b1;
            tgt_addr  <= chk_addr;
            hit_entry <= rd_entry;
          end else begin
            if (take) begin
              lead_score <= score;
              best_addr  <= chk_addr;
            end
            if (last_way) begin
              hit      <= 1'b0;
              tgt_addr <= take ? chk_addr : best_addr;
            end
          end
        end
      end
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (clr_cnt == AW'(DEPTH - 1)) begin
          clr_emit <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/clustered_aging_hash_table_top.sv =====
`timescale 1ns / 1ps
// Top level of the clustered aging hash table: configuration registers,
// result register and checks. Depends on caht_pkg and caht_engine.
//
// Store and retrieve walk the cluster in one synchronous entry memory, one
// way per cycle, bound by the single memory port: a hit ends the walk at the
// matching way, a miss reads all CLUSTER_WAYS ways. Clear rewrites every
// slot, one per cycle, and after reset the same pass runs over all
// 2^INDEX_BITS+CLUSTER_WAYS-1 slots (1027 by default) with in_stall high;
// configuration writes are taken meanwhile. The result register lets the
// next item be accepted while a result waits.
module clustered_aging_hash_table_top #(
  parameter int INDEX_BITS   = caht_pkg::INDEX_BITS_DEF,
  parameter int CLUSTER_WAYS = caht_pkg::CLUSTER_WAYS_DEF,
  parameter int DATE_COUNT   = caht_pkg::DATE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [caht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [caht_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     mode,
  input  logic [63:0]                    key,
  input  logic [15:0]                    move_code,
  input  logic signed [7:0]              search_depth,
  input  logic signed [15:0]             lower_bound,
  input  logic signed [15:0]             upper_bound,
  input  logic signed [15:0]             static_eval,
  input  logic                           refresh,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           found,
  output logic [15:0]                    hit_move,
  output logic signed [7:0]              hit_lower_depth,
  output logic signed [7:0]              hit_upper_depth,
  output logic signed [15:0]             hit_lower_bound,
  output logic signed [15:0]             hit_upper_bound,
  output logic signed [15:0]             hit_eval
);
  import caht_pkg::*;

  localparam int DB = $clog2(DATE_COUNT);

  logic [14:0]        value_infinity;
  logic signed [15:0] value_absent;
  logic [15:0]        move_absent;

  logic          res_ready, res_valid;
  result_t       res;
  logic [DB-1:0] cur_date;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_infinity <= VALUE_INFINITY_RST;
      value_absent   <= VALUE_ABSENT_RST;
      move_absent    <= MOVE_ABSENT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VALUE_INFINITY: value_infinity <= cfg_data[14:0];
        CFG_VALUE_ABSENT:   value_absent   <= $signed(cfg_data);
        CFG_MOVE_ABSENT:    move_absent    <= cfg_data;
        default: ;
      endcase
    end
  end

  caht_engine #(
    .INDEX_BITS  (INDEX_BITS),
    .CLUSTER_WAYS(CLUSTER_WAYS),
    .DATE_COUNT  (DATE_COUNT),
    .DB          (DB)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .key           (key),
    .move_code     (move_code),
    .search_depth  (search_depth),
    .lower_bound   (lower_bound),
    .upper_bound   (upper_bound),
    .static_eval   (static_eval),
    .refresh       (refresh),
    .value_infinity(value_infinity),
    .value_absent  (value_absent),
    .move_absent   (move_absent),
    .res_ready     (res_ready),
    .res_valid     (res_valid),
    .res           (res),
    .cur_date      (cur_date)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      found           <= res.found;
      hit_move        <= res.hit_move;
      hit_lower_depth <= res.hit_lower_depth;
      hit_upper_depth <= res.hit_upper_depth;
      hit_lower_bound <= res.hit_lower_bound;
      hit_upper_bound <= res.hit_upper_bound;
      hit_eval        <= res.hit_eval;
    end
  end

  // The engine never hands over a result while the register holds a stalled one.
  assert property (@(posedge clk) disable iff (rst) res_valid |-> res_ready)
    else $error("result issued into a full result register");

  // The date counter stays inside its modulus.
  assert property (@(posedge clk) disable iff (rst)
    {1'b0, cur_date} < (DB+1)'(DATE_COUNT))
    else $error("current date out of range");

  // A result without a hit carries all-zero fields.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (hit_move == '0 && hit_eval == '0 &&
      hit_lower_bound == '0 && hit_upper_bound == '0 &&
      hit_lower_depth == '0 && hit_upper_depth == '0))
    else $error("miss result with nonzero fields");

endmodule

// ===== tb/tb_clustered_aging_hash_table_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the clustered aging hash table: random and directed
// probes against a behavioral copy of the table. Depends on caht_pkg and the RTL.
module tb_clustered_aging_hash_table_top;
  import caht_pkg::*;

  localparam int NSLOT = 1027;
  localparam int WATCHDOG_LIMIT = 6000;

  typedef struct {
    logic [1:0]         mode;
    logic [63:0]        key;
    logic [15:0]        move_code;
    logic signed [7:0]  search_depth;
    logic signed [15:0] lower_bound;
    logic signed [15:0] upper_bound;
    logic signed [15:0] static_eval;
    logic               refresh;
  } probe_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_VALUE_INFINITY;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = MODE_STORE;
  logic [63:0] key = '0;
  logic [15:0] move_code = '0;
  logic signed [7:0] search_depth = '0;
  logic signed [15:0] lower_bound = '0;
  logic signed [15:0] upper_bound = '0;
  logic signed [15:0] static_eval = '0;
  logic refresh = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found;
  logic [15:0] hit_move;
  logic signed [7:0] hit_lower_depth, hit_upper_depth;
  logic signed [15:0] hit_lower_bound, hit_upper_bound, hit_eval;

  clustered_aging_hash_table_top u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioral copy of the table and its registers.
  logic [14:0] tbl_inf;
  logic signed [15:0] tbl_eval_absent;
  logic [15:0] tbl_move_absent;
  logic [3:0] tbl_date;
  logic [31:0] t_lock [NSLOT];
  logic [3:0] t_date [NSLOT];
  logic [15:0] t_move [NSLOT];
  int t_mdep [NSLOT];
  int t_ldep [NSLOT];
  int t_udep [NSLOT];
  logic signed [15:0] t_lo [NSLOT];
  logic signed [15:0] t_up [NSLOT];
  logic signed [15:0] t_eval [NSLOT];

  probe_t pending_probes[$];
  result_t expected_results[$];
  int errors = 0;
  int cyc = 0;

  function automatic void wipe_table();
    tbl_date = '0;
    for (int i = 0; i < NSLOT; i++) begin
      t_lock[i] = '0;
      t_date[i] = '0;
      t_move[i] = tbl_move_absent;
      t_mdep[i] = -128;
      t_ldep[i] = -128;
      t_udep[i] = -128;
      t_lo[i] = -$signed({1'b0, tbl_inf});
      t_up[i] = $signed({1'b0, tbl_inf});
      t_eval[i] = tbl_eval_absent;
    end
  endfunction

  function automatic void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    case (idx)
      CFG_VALUE_INFINITY: tbl_inf = val[14:0];
      CFG_VALUE_ABSENT: tbl_eval_absent = $signed(val);
      CFG_MOVE_ABSENT: tbl_move_absent = val;
      default: ;
    endcase
  endfunction

  function automatic result_t probe_table(probe_t p);
    result_t r;
    int base, e, best, score, top_score, dep, inf, lo, up, deep;
    logic [31:0] lk;
    logic [3:0] age;
    bit hit;
    r = '0;
    base = p.key[9:0];
    lk = p.key[63:32];
    hit = 0;
    inf = tbl_inf;
    case (p.mode)
      MODE_STORE: begin
        dep = p.search_depth;
        lo = p.lower_bound;
        up = p.upper_bound;
        best = base;
        top_score = -32767;
        for (int i = 0; i < 4 && !hit; i++) begin
          e = base + i;
          if (t_lock[e] == lk) begin
            hit = 1;
            t_date[e] = tbl_date;
            if (p.static_eval != tbl_eval_absent) t_eval[e] = p.static_eval;
            if (p.move_code != tbl_move_absent && dep >= t_mdep[e]) begin
              t_mdep[e] = dep;
              t_move[e] = p.move_code;
            end
            if (lo > -inf && dep >= t_ldep[e]) begin
              t_ldep[e] = dep;
              t_lo[e] = p.lower_bound;
            end
            if (up < inf && dep >= t_udep[e]) begin
              t_udep[e] = dep;
              t_up[e] = p.upper_bound;
            end
          end else begin
            age = tbl_date - t_date[e];
            deep = t_mdep[e];
            if (t_ldep[e] > deep) deep = t_ldep[e];
            if (t_udep[e] > deep) deep = t_udep[e];
            score = int'(age) * 256 - deep;
            if (score > top_score) begin
              top_score = score;
              best = e;
            end
          end
        end
        if (!hit) begin
          t_lock[best] = lk;
          t_date[best] = tbl_date;
          t_eval[best] = p.static_eval;
          t_move[best] = p.move_code;
          t_mdep[best] = (p.move_code != tbl_move_absent) ? dep : -128;
          t_ldep[best] = (lo > -inf) ? dep : -128;
          t_udep[best] = (up < inf) ? dep : -128;
          t_lo[best] = p.lower_bound;
          t_up[best] = p.upper_bound;
        end
      end
      MODE_RETRIEVE: begin
        for (int i = 0; i < 4 && !hit; i++) begin
          e = base + i;
          if (t_lock[e] == lk) begin
            hit = 1;
            if (p.refresh) t_date[e] = tbl_date;
            r.found = 1'b1;
            r.hit_move = t_move[e];
            r.hit_lower_depth = 8'(t_ldep[e]);
            r.hit_upper_depth = 8'(t_udep[e]);
            r.hit_lower_bound = t_lo[e];
            r.hit_upper_bound = t_up[e];
            r.hit_eval = t_eval[e];
          end
        end
      end
      MODE_ADVANCE: tbl_date = tbl_date + 4'd1;
      default: wipe_table();
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cyc, what, got, want);
    errors++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    probe_t p;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        p.mode = mode; p.key = key; p.move_code = move_code;
        p.search_depth = search_depth; p.lower_bound = lower_bound;
        p.upper_bound = upper_bound; p.static_eval = static_eval; p.refresh = refresh;
        expected_results.push_back(probe_table(p));
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_probes.size() > 0) begin
          p = pending_probes.pop_front();
          in_valid <= 1'b1;
          mode <= p.mode; key <= p.key; move_code <= p.move_code;
          search_depth <= p.search_depth; lower_bound <= p.lower_bound;
          upper_bound <= p.upper_bound; static_eval <= p.static_eval; refresh <= p.refresh;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall patterns, plus one long hold-off.
  int stall_style = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 200 == 0) stall_style <= $urandom_range(0, 3);
    if (cyc == 2600) begin
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= (cyc % 7 < 3);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk) begin
    result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item", found, 0);
      end else begin
        w = expected_results.pop_front();
        if (found !== w.found) report_mismatch("found", found, w.found);
        if (hit_move !== w.hit_move) report_mismatch("hit_move", hit_move, w.hit_move);
        if (hit_lower_depth !== w.hit_lower_depth)
          report_mismatch("hit_lower_depth", hit_lower_depth, w.hit_lower_depth);
        if (hit_upper_depth !== w.hit_upper_depth)
          report_mismatch("hit_upper_depth", hit_upper_depth, w.hit_upper_depth);
        if (hit_lower_bound !== w.hit_lower_bound)
          report_mismatch("hit_lower_bound", hit_lower_bound, w.hit_lower_bound);
        if (hit_upper_bound !== w.hit_upper_bound)
          report_mismatch("hit_upper_bound", hit_upper_bound, w.hit_upper_bound);
        if (hit_eval !== w.hit_eval) report_mismatch("hit_eval", hit_eval, w.hit_eval);
      end
    end
  end

  // Watchdog: a clear runs with nothing moving, and the limit allows for it.
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("[clustered_aging_hash_table_top] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic wait_drained();
    while (pending_probes.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    set_register(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic probe_t make_probe(logic [1:0] m, logic [9:0] base, logic [31:0] lk);
    probe_t p;
    p.mode = m;
    p.key = {lk, $urandom() & 32'hFFFFFC00 | 32'(base)};
    p.move_code = 16'($urandom());
    p.search_depth = 8'($urandom());
    p.lower_bound = 16'($urandom());
    p.upper_bound = 16'($urandom());
    p.static_eval = 16'($urandom());
    p.refresh = 1'($urandom());
    return p;
  endfunction

  task automatic add_random(int count);
    logic [9:0] bases [4];
    logic [31:0] locks [6];
    probe_t p;
    int r;
    logic [1:0] m;
    for (int i = 0; i < 4; i++) bases[i] = 10'($urandom());
    bases[0] = 10'h3FF;
    for (int i = 0; i < 6; i++) locks[i] = $urandom();
    locks[0] = '0;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 199);
      m = (r < 90) ? MODE_STORE : (r < 180) ? MODE_RETRIEVE :
          (r < 199) ? MODE_ADVANCE : MODE_CLEAR;
      p = make_probe(m, bases[$urandom_range(0, 3)], locks[$urandom_range(0, 5)]);
      if ($urandom_range(0, 9) == 0) p.key = {$urandom(), $urandom()};
      // Sentinels show up often so that the "nothing given" paths get exercised.
      if ($urandom_range(0, 3) == 0) p.lower_bound = -$signed({1'b0, tbl_inf});
      if ($urandom_range(0, 3) == 0) p.upper_bound = $signed({1'b0, tbl_inf});
      if ($urandom_range(0, 3) == 0) p.static_eval = tbl_eval_absent;
      if ($urandom_range(0, 3) == 0) p.move_code = tbl_move_absent;
      if ($urandom_range(0, 1) == 0) p.search_depth = 8'($urandom_range(0, 12) - 6);
      pending_probes.push_back(p);
    end
  endtask

  task automatic add_directed();
    probe_t p;
    // A zero lock matches the cleared entries of the cluster.
    p = make_probe(MODE_RETRIEVE, 10'd0, 32'd0);
    pending_probes.push_back(p);
    p = make_probe(MODE_STORE, 10'd0, 32'd0);
    p.search_depth = 8'sd127; p.lower_bound = 16'sh8000; p.upper_bound = 16'sh7FFF;
    pending_probes.push_back(p);
    p = make_probe(MODE_RETRIEVE, 10'd0, 32'd0);
    pending_probes.push_back(p);
    // Five locks into the top cluster force replacements.
    for (int i = 1; i <= 5; i++) begin
      p = make_probe(MODE_STORE, 10'h3FF, 32'hFFFF_FFF0 + i);
      p.search_depth = (i == 3) ? -8'sd128 : 8'(i);
      p.move_code = (i == 2) ? tbl_move_absent : 16'hFFFF;
      p.lower_bound = -$signed({1'b0, tbl_inf});
      p.upper_bound = $signed({1'b0, tbl_inf});
      p.static_eval = tbl_eval_absent;
      pending_probes.push_back(p);
      if (i == 4) pending_probes.push_back(make_probe(MODE_ADVANCE, 10'd5, 32'd1));
    end
    for (int i = 1; i <= 5; i++) begin
      p = make_probe(MODE_RETRIEVE, 10'h3FF, 32'hFFFF_FFF0 + i);
      p.refresh = i[0];
      pending_probes.push_back(p);
    end
    pending_probes.push_back(make_probe(MODE_RETRIEVE, 10'h155, 32'hDEAD_BEEF));
    pending_probes.push_back(make_probe(MODE_CLEAR, 10'h3FF, 32'hFFFF_FFFF));
    pending_probes.push_back(make_probe(MODE_RETRIEVE, 10'h3FF, 32'd0));
    pending_probes.push_back(make_probe(MODE_RETRIEVE, 10'h3FF, 32'hFFFF_FFF1));
  endtask

  initial begin
    tbl_inf = VALUE_INFINITY_RST;
    tbl_eval_absent = VALUE_ABSENT_RST;
    tbl_move_absent = MOVE_ABSENT_RST;
    wipe_table();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    add_directed();
    add_random(240);
    wait_drained();
    write_reg(CFG_VALUE_INFINITY, 16'd32767);
    write_reg(CFG_VALUE_ABSENT, 16'd32767);
    write_reg(CFG_MOVE_ABSENT, 16'hFFFF);
    add_random(240);
    wait_drained();
    write_reg(CFG_VALUE_INFINITY, 16'd1);
    write_reg(CFG_VALUE_ABSENT, -16'sd32767);
    write_reg(CFG_MOVE_ABSENT, 16'd0);
    pending_probes.push_back(make_probe(MODE_CLEAR, 10'd0, 32'd0));
    add_random(240);
    wait_drained();
    write_reg(CFG_VALUE_INFINITY, 16'($urandom_range(2, 32766)));
    write_reg(CFG_VALUE_ABSENT, 16'd0);
    write_reg(CFG_MOVE_ABSENT, 16'($urandom()));
    add_random(240);
    wait_drained();
    write_reg(CFG_VALUE_INFINITY, 16'(VALUE_INFINITY_RST));
    write_reg(CFG_VALUE_ABSENT, VALUE_ABSENT_RST);
    write_reg(CFG_MOVE_ABSENT, MOVE_ABSENT_RST);
    pending_probes.push_back(make_probe(MODE_CLEAR, 10'd0, 32'd0));
    add_random(240);
    wait_drained();
    if (errors == 0) begin
      $display("[clustered_aging_hash_table_top] OK");
    end else begin
      $display("[clustered_aging_hash_table_top] ERROR");
    end
    $finish;
  end

endmodule
